// ===== rtl/cpa_pkg.sv =====
package cpa_pkg;

    localparam int MAX_PAGES  = 1024;
    localparam int PAGE_BYTES = 256;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PG_W       = $clog2(MAX_PAGES);
    localparam int CNT_W      = $clog2(MAX_PAGES + 1);
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 19;
    localparam int NEED_W     = SIZE_W + 1 - PAGE_SHIFT;
    localparam int PCNT_W     = 11;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int FLAG_W     = 2;

    localparam logic [PCNT_W-1:0] PCNT_RESET = PCNT_W'(1024);

    localparam logic [FLAG_W-1:0] FLAG_TAKEN = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_LAST  = 2'b10;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b1;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_FREED     = 2'd2,
        ST_IGNORED   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_ALLOC_WR,
        S_FREE_RD,
        S_FREE_RUN,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_func              func;
        logic [SIZE_W-1:0]  size_bytes;
        logic [ADDR_W-1:0]  block_addr;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr_out;
        t_status            status;
    } t_out_item;

    typedef struct packed {
        logic    clr_wr;
        logic    start;
        logic    decode;
        logic    scan;
        logic    alloc_wr;
        logic    free_run;
        logic    out_load;
        t_status res_st;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic alloc_ok;
        logic free_ok;
        logic hit;
        logic exhausted;
        logic wr_done;
        logic f_taken;
        logic f_last;
        logic f_end;
        logic f_first;
        logic out_ready;
    } t_stat;

endpackage

// ===== rtl/cpa_ram.sv =====
module cpa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cpa_ctrl.sv =====
module cpa_ctrl
    import cpa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state  r_state, n_state;
    t_status r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_st    <= ST_IGNORED;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_st         = r_st;
        o_cmd        = '0;
        o_cmd.res_st = r_st;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_stat.is_free) begin
                    if (i_stat.free_ok) begin
                        n_state = S_FREE_RD;
                    end else begin
                        n_st    = ST_IGNORED;
                        n_state = S_FINISH;
                    end
                end else if (i_stat.alloc_ok) begin
                    n_state = S_SCAN;
                end else begin
                    n_st    = ST_NO_SPACE;
                    n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_ALLOC_WR;
                end else if (i_stat.exhausted) begin
                    n_st    = ST_NO_SPACE;
                    n_state = S_FINISH;
                end
            end
            S_ALLOC_WR: begin
                o_cmd.alloc_wr = 1'b1;
                if (i_stat.wr_done) begin
                    n_st    = ST_ALLOCATED;
                    n_state = S_FINISH;
                end
            end
            S_FREE_RD: begin
                n_state = S_FREE_RUN;
            end
            S_FREE_RUN: begin
                o_cmd.free_run = 1'b1;
                if (!i_stat.f_taken) begin
                    n_st    = i_stat.f_first ? ST_IGNORED : ST_FREED;
                    n_state = S_FINISH;
                end else if (i_stat.f_last || i_stat.f_end) begin
                    n_st    = ST_FREED;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_free_run_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FREE_RUN |->
            ($past(r_state) == S_FREE_RD || $past(r_state) == S_FREE_RUN))
        else $error("free walk entered without a first read");

endmodule

// ===== rtl/cpa_dpath.sv =====
module cpa_dpath
    import cpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  t_in_item             i_in_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_out_valid,
    output t_out_item            o_out_data,
    input  logic                 i_out_stall
);

    logic [PCNT_W-1:0] r_page_count;
    logic [ADDR_W-1:0] r_heap_base;
    t_func             r_func;
    logic [NEED_W-1:0] r_need;
    logic [ADDR_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_pg;
    logic [CNT_W-1:0]  r_run;
    logic [CNT_W-1:0]  r_chk_pg;
    logic              r_chk_vld;
    logic [CNT_W-1:0]  r_start;
    logic [CNT_W-1:0]  r_end;
    logic              r_first;
    logic              r_out_vld;
    t_out_item         r_out;

    logic [CNT_W-1:0]             n_pages;
    logic [ADDR_W-1:0]            base_al;
    logic [ADDR_W-1:0]            offset;
    logic [ADDR_W-PAGE_SHIFT-1:0] off_page;
    logic [SIZE_W:0]              size_up;
    logic [NEED_W-1:0]            need_raw;
    logic [NEED_W-1:0]            need;
    logic [CNT_W-1:0]             pg_inc;
    logic [NEED_W-1:0]            run_inc;
    logic [CNT_W-1:0]             hit_start;
    logic [ADDR_W-1:0]            res_addr;
    logic                         hit;
    logic                         exhausted;
    logic                         wr_done;
    logic                         ram_we;
    logic [FLAG_W-1:0]            ram_wdata;
    logic [PG_W-1:0]              ram_raddr;
    logic [FLAG_W-1:0]            rd_data;

    assign n_pages  = (r_page_count > PCNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                          : CNT_W'(r_page_count);
    assign base_al  = {r_heap_base[ADDR_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)};
    assign offset   = r_addr - base_al;
    assign off_page = offset[ADDR_W-1:PAGE_SHIFT];

    assign size_up  = {1'b0, i_in_data.size_bytes} + (SIZE_W+1)'(PAGE_BYTES - 1);
    assign need_raw = size_up[SIZE_W:PAGE_SHIFT];
    assign need     = (need_raw == '0) ? NEED_W'(1) : need_raw;

    assign pg_inc    = r_pg + CNT_W'(1);
    assign run_inc   = NEED_W'(r_run) + NEED_W'(1);
    assign hit_start = r_chk_pg - CNT_W'(r_need - NEED_W'(1));
    assign hit       = r_chk_vld && !rd_data[0] && (run_inc == r_need);
    assign exhausted = r_chk_vld && !hit && (r_chk_pg == n_pages - CNT_W'(1));
    assign wr_done   = (r_pg == r_end);
    assign res_addr  = base_al + (ADDR_W'(r_start) << PAGE_SHIFT);

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= PCNT_RESET;
            r_heap_base  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_PAGE_COUNT) begin
                r_page_count <= i_cfg_data[PCNT_W-1:0];
            end else if (i_cfg_idx == CFG_HEAP_BASE) begin
                r_heap_base <= i_cfg_data[ADDR_W-1:0];
            end
        end
    end

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func <= i_in_data.func;
            r_need <= need;
            r_addr <= i_in_data.block_addr;
        end
    end

    // page pointer and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pg      <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_chk_vld <= i_cmd.scan;
            priority if (i_cmd.decode) begin
                r_pg <= (r_func == FUNC_FREE) ? CNT_W'(off_page) : '0;
            end else if (i_cmd.scan && hit) begin
                r_pg <= hit_start;
            end else if (i_cmd.clr_wr || i_cmd.scan || i_cmd.alloc_wr || i_cmd.free_run) begin
                r_pg <= pg_inc;
            end else begin
                r_pg <= r_pg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_run   <= '0;
            r_first <= 1'b1;
        end else begin
            if (i_cmd.scan && r_chk_vld) begin
                r_run <= rd_data[0] ? '0 : CNT_W'(run_inc);
            end
            if (i_cmd.free_run) begin
                r_first <= 1'b0;
            end
        end
        if (i_cmd.scan) begin
            r_chk_pg <= r_pg;
        end
        if (i_cmd.scan && hit) begin
            r_start <= hit_start;
            r_end   <= r_chk_pg;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.addr_out <= (i_cmd.res_st == ST_ALLOCATED) ? res_addr : '0;
            r_out.status   <= i_cmd.res_st;
        end
    end

    assign ram_we    = i_cmd.clr_wr || i_cmd.alloc_wr || (i_cmd.free_run && rd_data[0]);
    assign ram_wdata = i_cmd.alloc_wr ? (FLAG_TAKEN | (wr_done ? FLAG_LAST : '0)) : '0;
    assign ram_raddr = i_cmd.free_run ? pg_inc[PG_W-1:0] : r_pg[PG_W-1:0];

    cpa_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (MAX_PAGES)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pg[PG_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    always_comb begin
        o_stat           = '0;
        o_stat.clr_done  = (r_pg[PG_W-1:0] == PG_W'(MAX_PAGES - 1));
        o_stat.is_free   = (r_func == FUNC_FREE);
        o_stat.alloc_ok  = (r_need <= NEED_W'(n_pages));
        o_stat.free_ok   = (r_addr != '0) && (r_addr >= base_al)
                           && (off_page < (ADDR_W-PAGE_SHIFT)'(n_pages));
        o_stat.hit       = hit;
        o_stat.exhausted = exhausted;
        o_stat.wr_done   = wr_done;
        o_stat.f_taken   = rd_data[0];
        o_stat.f_last    = rd_data[1];
        o_stat.f_end     = (pg_inc == n_pages);
        o_stat.f_first   = r_first;
        o_stat.out_ready = !r_out_vld || !i_out_stall;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_vld || !i_out_stall))
        else $error("pending result overwritten");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && r_chk_vld) |-> (r_chk_pg < n_pages))
        else $error("scan past last heap page");

    a_mark_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc_wr |-> (r_pg >= r_start && r_pg <= r_end))
        else $error("allocation write outside found run");

endmodule

// ===== rtl/contiguous_page_allocator_unit.sv =====
// allocate scans the page flags for a free run, then marks the pages of that run as taken
// a failed scan ends at the last heap page; free walks the block's pages and clears them
// requests ignored without a table read and allocations larger than the heap skip the walk
// one transaction at a time, set by the serial walk over the page flag memory
// synchronous active-low reset; afterwards a clearing pass over every page flag empties the flags
// and no request is taken until it ends; configuration writes are taken throughout
module contiguous_page_allocator_unit
    import cpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_in_item             i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output t_out_item            o_out_data,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    cpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cpa_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== tb/tb_contiguous_page_allocator_unit.sv =====
module tb_contiguous_page_allocator_unit;
    import cpa_pkg::*;

    typedef struct packed {
        logic     drain;
        t_in_item item;
    } t_request;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    t_in_item             i_in_data = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_item            o_out_data;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // shadow of the page table and registers
    logic [FLAG_W-1:0] page_table [MAX_PAGES];
    logic [PCNT_W-1:0] heap_pages_reg;
    logic [ADDR_W-1:0] heap_base_reg;
    int                live_pages [$];

    t_request  request_q [$];
    t_out_item due_results [$];
    int        err_cnt = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    contiguous_page_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #40000000;
        $display("tb_contiguous_page_allocator_unit: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (err_cnt < 200) begin
            $display("mismatch: %s", msg);
        end
        err_cnt++;
    endtask

    function automatic int heap_pages();
        return (heap_pages_reg > PCNT_W'(MAX_PAGES)) ? MAX_PAGES : int'(heap_pages_reg);
    endfunction

    function automatic logic [ADDR_W-1:0] page_base();
        return heap_base_reg & ~ADDR_W'(PAGE_BYTES - 1);
    endfunction

    function automatic t_out_item allocate_pages(input logic [SIZE_W-1:0] size);
        t_out_item r;
        int        n;
        int        need;
        int        run;
        int        start;
        n    = heap_pages();
        need = (int'(size) + PAGE_BYTES - 1) / PAGE_BYTES;
        run  = 0;
        if (need == 0) begin
            need = 1;
        end
        r.addr_out = '0;
        r.status   = ST_NO_SPACE;
        if (need > n) begin
            return r;
        end
        for (int i = 0; i < n; i++) begin
            if ((page_table[i] & FLAG_TAKEN) != '0) begin
                run = 0;
            end else begin
                run++;
                if (run == need) begin
                    start = i + 1 - run;
                    for (int k = start; k < i; k++) begin
                        page_table[k] = FLAG_TAKEN;
                    end
                    page_table[i] = FLAG_TAKEN | FLAG_LAST;
                    r.addr_out = page_base() + ADDR_W'(start * PAGE_BYTES);
                    r.status   = ST_ALLOCATED;
                    live_pages.push_back(start);
                    return r;
                end
            end
        end
        return r;
    endfunction

    function automatic t_out_item release_pages(input logic [ADDR_W-1:0] addr);
        t_out_item r;
        longint    a;
        longint    b;
        longint    pg;
        int        n;
        int        p;
        logic      last;
        n = heap_pages();
        a = addr;
        b = page_base();
        r.addr_out = '0;
        r.status   = ST_IGNORED;
        if (addr == '0 || a < b) begin
            return r;
        end
        pg = (a - b) / PAGE_BYTES;
        if (pg >= n) begin
            return r;
        end
        p = int'(pg);
        if ((page_table[p] & FLAG_TAKEN) == '0) begin
            return r;
        end
        while (p < n && (page_table[p] & FLAG_TAKEN) != '0) begin
            last = (page_table[p] & FLAG_LAST) != '0;
            page_table[p] = '0;
            if (last) begin
                break;
            end
            p++;
        end
        r.status = ST_FREED;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin : driver
        t_request nxt;
        logic     hold;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (i_in_data.func == FUNC_ALLOC) begin
                    due_results.push_back(allocate_pages(i_in_data.size_bytes));
                end else begin
                    due_results.push_back(release_pages(i_in_data.block_addr));
                end
            end
            if (!i_in_valid || !o_in_stall) begin
                hold = (request_q.size() == 0) || ($urandom_range(99) < send_idle_pct);
                if (!hold && request_q[0].drain && due_results.size() != 0) begin
                    hold = 1'b1;
                end
                if (hold) begin
                    i_in_valid <= 1'b0;
                end else begin
                    nxt = request_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_data  <= nxt.item;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction addr %h status %0d",
                                              o_out_data.addr_out, o_out_data.status));
                end else begin
                    want = due_results.pop_front();
                    if (o_out_data.addr_out !== want.addr_out) begin
                        report_mismatch($sformatf("addr_out %h, want %h",
                                                  o_out_data.addr_out, want.addr_out));
                    end
                    if (o_out_data.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  o_out_data.status, want.status));
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic queue_request(input t_func f, input int size, input logic [ADDR_W-1:0] addr,
                                 input logic drain);
        t_request q;
        q.drain           = drain;
        q.item.func       = f;
        q.item.size_bytes = SIZE_W'(size);
        q.item.block_addr = addr;
        request_q.push_back(q);
    endtask

    task automatic wait_quiet();
        while (request_q.size() != 0 || i_in_valid || due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PAGE_COUNT) begin
            heap_pages_reg = value[PCNT_W-1:0];
        end else begin
            heap_base_reg = value;
        end
    endtask

    task automatic queue_random_request();
        t_request q;
        int       n;
        int       lim;
        int       roll;
        int       idx;
        int       pg;
        n    = heap_pages();
        lim  = (n < 16) ? n : 16;
        roll = $urandom_range(99);
        q.drain           = ($urandom_range(49) == 0);
        q.item.size_bytes = SIZE_W'($urandom);
        q.item.block_addr = $urandom;
        if (roll < 50) begin
            q.item.func = FUNC_ALLOC;
            case ($urandom_range(9))
                0:       q.item.size_bytes = SIZE_W'($urandom);
                1:       q.item.size_bytes = ($urandom_range(1) == 0) ? '0 : SIZE_W'(262144);
                default: q.item.size_bytes = SIZE_W'($urandom_range(lim * PAGE_BYTES));
            endcase
        end else if (roll < 88 && live_pages.size() > 0) begin
            q.item.func = FUNC_FREE;
            idx = $urandom_range(live_pages.size() - 1);
            pg  = live_pages[idx];
            live_pages.delete(idx);
            q.item.block_addr = page_base() + ADDR_W'(pg * PAGE_BYTES);
            case ($urandom_range(3))
                2:       q.item.block_addr += ADDR_W'($urandom_range(PAGE_BYTES - 1));
                3:       q.item.block_addr += ADDR_W'($urandom_range(8) * PAGE_BYTES
                                                      + $urandom_range(PAGE_BYTES - 1));
                default: ;
            endcase
        end else begin
            q.item.func = t_func'($urandom_range(1));
            case ($urandom_range(3))
                0:       ;
                1:       q.item.block_addr = '0;
                2:       q.item.block_addr = page_base()
                                             + ADDR_W'($urandom_range(n + 4) * PAGE_BYTES
                                                       + $urandom_range(PAGE_BYTES - 1));
                default: q.item.block_addr = page_base() - ADDR_W'($urandom_range(1, 4096));
            endcase
        end
        request_q.push_back(q);
    endtask

    task automatic run_random_phase(input int count, input logic [CFG_W-1:0] pages_word,
                                    input logic [CFG_W-1:0] base_word);
        wait_quiet();
        write_reg(CFG_PAGE_COUNT, pages_word);
        write_reg(CFG_HEAP_BASE, base_word);
        repeat (count) begin
            while (request_q.size() >= 2) begin
                @(posedge i_clk);
            end
            queue_random_request();
        end
    endtask

    initial begin : stimulus
        for (int i = 0; i < MAX_PAGES; i++) begin
            page_table[i] = '0;
        end
        heap_pages_reg = PCNT_RESET;
        heap_base_reg  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 46;

        // reset configuration: 1024 pages from address 0
        queue_request(FUNC_ALLOC, 0, 32'h0, 1'b0);
        queue_request(FUNC_ALLOC, 1, 32'h0, 1'b0);
        queue_request(FUNC_ALLOC, 256, 32'h0, 1'b0);
        queue_request(FUNC_ALLOC, 257, 32'h0, 1'b0);
        queue_request(FUNC_ALLOC, 262144, 32'h0, 1'b0);
        queue_request(FUNC_ALLOC, 32'h7FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_request(FUNC_FREE, 0, 32'h0, 1'b0);
        queue_request(FUNC_FREE, 0, 32'h111, 1'b0);
        queue_request(FUNC_FREE, 32'h7FFFF, 32'h100, 1'b0);
        queue_request(FUNC_FREE, 0, 32'h4FF, 1'b0);
        queue_request(FUNC_FREE, 0, 32'h300, 1'b0);
        queue_request(FUNC_FREE, 0, 32'h4_0000, 1'b0);
        queue_request(FUNC_FREE, 0, 32'hFFFF_FFFF, 1'b0);
        queue_request(FUNC_ALLOC, 32'h1000, 32'h0, 1'b1);

        // heap cut through a 16-page block
        wait_quiet();
        write_reg(CFG_PAGE_COUNT, 32'd8);
        write_reg(CFG_HEAP_BASE, 32'h0);
        queue_request(FUNC_FREE, 0, 32'h300, 1'b0);
        queue_request(FUNC_ALLOC, 32'h800, 32'h0, 1'b0);

        // no heap at all
        wait_quiet();
        write_reg(CFG_PAGE_COUNT, 32'd0);
        queue_request(FUNC_ALLOC, 0, 32'h0, 1'b0);
        queue_request(FUNC_FREE, 0, 32'h100, 1'b0);

        // oversized page count, unaligned base near the top of the address space
        wait_quiet();
        write_reg(CFG_PAGE_COUNT, 32'hFFFF_FFFF);
        write_reg(CFG_HEAP_BASE, 32'hFFFF_FF3C);
        queue_request(FUNC_ALLOC, 1, 32'h0, 1'b0);
        queue_request(FUNC_FREE, 0, 32'h0, 1'b0);
        queue_request(FUNC_ALLOC, 1, 32'h0, 1'b0);
        queue_request(FUNC_FREE, 0, 32'h200, 1'b0);
        queue_request(FUNC_FREE, 0, 32'hFFFF_FF00, 1'b0);
        queue_request(FUNC_FREE, 0, 32'hFFFF_FF80, 1'b0);

        run_random_phase(100, 32'd16, 32'h1000_0000);
        run_random_phase(60, 32'hABCD_E001, 32'hFFFF_FFFF);

        wait_quiet();
        send_idle_pct = 46;
        recv_idle_pct = 12;
        run_random_phase(120, 32'd2047, 32'h8000_0080);
        run_random_phase(100, 32'd40, $urandom);

        wait_quiet();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(100, 32'd1024, 32'hFFFF_0000);
        run_random_phase(100, {21'($urandom_range(1, 1023)), 11'($urandom_range(2, 64))},
                         $urandom);

        wait_quiet();
        repeat (2100) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_contiguous_page_allocator_unit: done, clean");
        end else begin
            $display("tb_contiguous_page_allocator_unit: done, errors");
        end
        $finish;
    end

endmodule
